>>> hw/rtl/kwtc_pkg.sv
// Package for the keyword token classifier.
// Holds the action codes, FNV-1a constants and the controller state type.
// No dependencies.
package kwtc_pkg;

  // Width of the fixed payload fields.
  localparam int unsigned ActionW   = 2;
  localparam int unsigned RowIndexW = 6;
  localparam int unsigned HashW     = 32;
  localparam int unsigned ClassW    = 3;
  localparam int unsigned CharW     = 8;
  localparam int unsigned RowsW     = 7;

  // FNV-1a 32-bit constants.
  localparam logic [HashW-1:0] FnvBasis = 32'h811C_9DC5;
  localparam logic [HashW-1:0] FnvPrime = 32'h0100_0193;

  // Character codes used by the classifier.
  localparam logic [CharW-1:0] CharNul    = 8'h00;
  localparam logic [CharW-1:0] CharUpperA = 8'h41;
  localparam logic [CharW-1:0] CharUpperZ = 8'h5A;
  localparam logic [CharW-1:0] CharLowerA = 8'h61;
  localparam logic [CharW-1:0] CharLowerZ = 8'h7A;
  localparam logic [CharW-1:0] CaseBit    = 8'h20;

  // Input beat kinds.
  typedef enum logic [ActionW-1:0] {
    ACT_ROW  = 2'd0,
    ACT_CHAR = 2'd1,
    ACT_END  = 2'd2
  } action_e;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_LOOK = 3'b010,
    ST_EMIT = 3'b100
  } state_e;

endpackage

>>> hw/rtl/kwtc_if.sv
// Valid/ready channel interfaces for the keyword token classifier.
// kwtc_in_if carries input beats, kwtc_out_if carries class mask results.
// Depends on kwtc_pkg for field widths.
interface kwtc_in_if
  import kwtc_pkg::*;
;
  logic                 valid;
  logic                 ready;
  logic [ActionW-1:0]   action;
  logic [RowIndexW-1:0] row_index;
  logic [HashW-1:0]     row_hash;
  logic [ClassW-1:0]    row_class;
  logic [CharW-1:0]     char_byte;

  modport source (
    output valid, action, row_index, row_hash, row_class, char_byte,
    input  ready
  );
  modport sink (
    input  valid, action, row_index, row_hash, row_class, char_byte,
    output ready
  );
endinterface

interface kwtc_out_if
  import kwtc_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [ClassW-1:0] class_mask;

  modport source (
    output valid, class_mask,
    input  ready
  );
  modport sink (
    input  valid, class_mask,
    output ready
  );
endinterface

>>> hw/rtl/keyword_token_classifier.sv
// Keyword token classifier: FNV-1a hashing of letter runs, table lookup by binary search.
// Row writes and letters are taken in the idle state. A run that ends and qualifies for
// lookup starts a binary search of up to log2(TABLE_DEPTH)+1 steps (7 for 64 rows),
// paced by the single read port of the table memory. An end beat loads the output
// register. Reset clears the run, mask and control state; the table memory is not
// cleared and must be written before it is searched.
module keyword_token_classifier
  import kwtc_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH   = 64,
  parameter int unsigned MAX_TOKEN_LEN = 16,
  parameter int unsigned MIN_TOKEN_LEN = 3
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [RowsW-1:0] cfg_wdata_i,
  kwtc_in_if.sink          in_i,
  kwtc_out_if.source       out_o
);

  localparam int unsigned AddrW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CntW  = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned LenW  = $clog2(MAX_TOKEN_LEN + 1);
  localparam int unsigned EntW  = HashW + ClassW;

  // Table memory: key in the upper bits, class in the lower bits.
  logic [EntW-1:0] table_mem [TABLE_DEPTH];
  logic [EntW-1:0] rd_data_q;
  logic            rd_en;
  logic [AddrW-1:0] rd_addr;
  logic            wr_en;

  // Control and per-name state.
  state_e            state_q, state_d;
  logic [RowsW-1:0]  rows_q;
  logic [HashW-1:0]  run_hash_q, run_hash_d;
  logic [LenW-1:0]   run_letters_q, run_letters_d;
  logic              run_too_long_q, run_too_long_d;
  logic [ClassW-1:0] mask_q, mask_d;
  logic              stopped_q, stopped_d;
  logic              end_pend_q, end_pend_d;
  logic [HashW-1:0]  key_q, key_d;
  logic [CntW-1:0]   lo_q, lo_d, hi_q, hi_d, mid_q, mid_d;
  logic              out_valid_q, out_valid_d;
  logic [ClassW-1:0] out_mask_q, out_mask_d;

  // Combinational helpers.
  logic             accept;
  logic [CharW-1:0] ch, ch_low;
  logic             is_upper, is_lower;
  logic [HashW-1:0] hash_mul;
  logic             qualifies;
  logic [CntW-1:0]  hi_init;
  logic [HashW-1:0] rd_key;
  logic [ClassW-1:0] rd_cls;
  logic [CntW-1:0]  nlo, nhi, nmid;

  assign accept = in_i.valid && in_i.ready;
  assign in_i.ready = (state_q == ST_IDLE);
  assign out_o.valid = out_valid_q;
  assign out_o.class_mask = out_mask_q;

  // Character decode and FNV-1a step.
  assign ch       = in_i.char_byte;
  assign is_upper = (ch >= CharUpperA) && (ch <= CharUpperZ);
  assign is_lower = (ch >= CharLowerA) && (ch <= CharLowerZ);
  assign ch_low   = is_upper ? (ch | CaseBit) : ch;
  assign hash_mul = HashW'((run_hash_q ^ {{(HashW-CharW){1'b0}}, ch_low}) * FnvPrime);

  // The run is looked up only if it is long enough and was not cut short.
  assign qualifies = (32'(run_letters_q) >= 32'(MIN_TOKEN_LEN)) && !run_too_long_q;
  assign hi_init   = (9'(rows_q) > 9'(TABLE_DEPTH)) ? CntW'(TABLE_DEPTH) : CntW'(rows_q);

  // Next search bounds from the row just read.
  assign rd_key = rd_data_q[EntW-1:ClassW];
  assign rd_cls = rd_data_q[ClassW-1:0];
  assign nlo    = (rd_key < key_q) ? (mid_q + CntW'(1)) : lo_q;
  assign nhi    = (rd_key < key_q) ? hi_q : mid_q;
  assign nmid   = nlo + ((nhi - nlo) >> 1);

  assign wr_en = accept && (in_i.action == ACT_ROW)
                 && (32'(in_i.row_index) < 32'(TABLE_DEPTH));

  // Next-state logic for the controller and per-name state.
  always_comb begin
    state_d        = state_q;
    run_hash_d     = run_hash_q;
    run_letters_d  = run_letters_q;
    run_too_long_d = run_too_long_q;
    mask_d         = mask_q;
    stopped_d      = stopped_q;
    end_pend_d     = end_pend_q;
    key_d          = key_q;
    lo_d           = lo_q;
    hi_d           = hi_q;
    mid_d          = mid_q;
    out_valid_d    = out_valid_q && !out_o.ready;
    out_mask_d     = out_mask_q;
    rd_en          = 1'b0;
    rd_addr        = AddrW'(mid_q);

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (in_i.action)
            ACT_CHAR: begin
              if (!stopped_q) begin
                if (is_upper || is_lower) begin
                  if (32'(run_letters_q) < 32'(MAX_TOKEN_LEN)) begin
                    run_hash_d    = hash_mul;
                    run_letters_d = run_letters_q + LenW'(1);
                  end else begin
                    run_too_long_d = 1'b1;
                  end
                end else begin
                  // A delimiter flushes the run; NUL also stops the name.
                  run_hash_d     = FnvBasis;
                  run_letters_d  = '0;
                  run_too_long_d = 1'b0;
                  if (ch == CharNul) begin
                    stopped_d = 1'b1;
                  end
                  end_pend_d = 1'b0;
                  if (qualifies && (hi_init != '0)) begin
                    key_d   = run_hash_q;
                    lo_d    = '0;
                    hi_d    = hi_init;
                    mid_d   = hi_init >> 1;
                    rd_en   = 1'b1;
                    rd_addr = AddrW'(hi_init >> 1);
                    state_d = ST_LOOK;
                  end
                end
              end
            end
            ACT_END: begin
              run_hash_d     = FnvBasis;
              run_letters_d  = '0;
              run_too_long_d = 1'b0;
              stopped_d      = 1'b0;
              end_pend_d     = 1'b1;
              if (qualifies && (hi_init != '0)) begin
                key_d   = run_hash_q;
                lo_d    = '0;
                hi_d    = hi_init;
                mid_d   = hi_init >> 1;
                rd_en   = 1'b1;
                rd_addr = AddrW'(hi_init >> 1);
                state_d = ST_LOOK;
              end else begin
                state_d = ST_EMIT;
              end
            end
            default: begin
              // Row writes go straight to the memory; other codes do nothing.
            end
          endcase
        end
      end

      ST_LOOK: begin
        // Compare the row read last cycle and issue the next read at once.
        if (rd_key == key_q) begin
          mask_d  = mask_q | rd_cls;
          state_d = end_pend_q ? ST_EMIT : ST_IDLE;
        end else begin
          lo_d  = nlo;
          hi_d  = nhi;
          mid_d = nmid;
          if (nlo < nhi) begin
            rd_en   = 1'b1;
            rd_addr = AddrW'(nmid);
          end else begin
            state_d = end_pend_q ? ST_EMIT : ST_IDLE;
          end
        end
      end

      ST_EMIT: begin
        // Load the output register once it is free.
        if (!out_valid_q || out_o.ready) begin
          out_valid_d = 1'b1;
          out_mask_d  = mask_q;
          mask_d      = '0;
          end_pend_d  = 1'b0;
          state_d     = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Table memory with a registered read port.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      table_mem[AddrW'(in_i.row_index)] <= {in_i.row_hash, in_i.row_class};
    end
    if (rd_en) begin
      rd_data_q <= table_mem[rd_addr];
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      rows_q         <= '0;
      run_hash_q     <= FnvBasis;
      run_letters_q  <= '0;
      run_too_long_q <= 1'b0;
      mask_q         <= '0;
      stopped_q      <= 1'b0;
      end_pend_q     <= 1'b0;
      out_valid_q    <= 1'b0;
    end else begin
      state_q        <= state_d;
      if (cfg_we_i) begin
        rows_q <= cfg_wdata_i;
      end
      run_hash_q     <= run_hash_d;
      run_letters_q  <= run_letters_d;
      run_too_long_q <= run_too_long_d;
      mask_q         <= mask_d;
      stopped_q      <= stopped_d;
      end_pend_q     <= end_pend_d;
      out_valid_q    <= out_valid_d;
    end
  end

  // Search and output payload registers.
  always_ff @(posedge clk_i) begin
    key_q      <= key_d;
    lo_q       <= lo_d;
    hi_q       <= hi_d;
    mid_q      <= mid_d;
    out_mask_q <= out_mask_d;
  end

endmodule
